// File: hw/rtl/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker package
// Shared sizes, status codes, state type and the structs that pass between
// the walk sequencer, the entry store and the top level.
// ----------------------------------------------------------------------------
package ptw_pkg;

   // Store geometry: TABLE_PAGES pages of 512 entry words each.
   localparam int TABLE_PAGES      = 64;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int IDX_W            = 9;
   localparam int PAGE_W           = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int ADDR_W           = PAGE_W + IDX_W;
   localparam int STORE_WORDS      = TABLE_PAGES * ENTRIES_PER_PAGE;

   // Field widths fixed by the interface.
   localparam int ROOT_W   = 6;
   localparam int VA_W     = 64;
   localparam int WIDX_W   = 15;
   localparam int PTE_W    = 64;
   localparam int PA_W     = 56;
   localparam int STATUS_W = 3;
   localparam int PN_W     = PTE_W - 10;

   // Entry bits.
   localparam int PTE_VALID_BIT = 0;
   localparam int PTE_USER_BIT  = 4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_HIGH     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_USER = 3'd3;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_WRITE    = 3'd5;

   // Input function codes.
   localparam logic FUNC_WRITE     = 1'b0;
   localparam logic FUNC_TRANSLATE = 1'b1;

   // Walk sequencer states: idle, then one state per table level.
   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_L2,
      WALK_L1,
      WALK_L0
   } walk_state_type;

   // Access request from the sequencer to the entry store.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      logic [PTE_W-1:0]  wr_data;
   } store_req_type;

   // Finished result handed to the output register.
   typedef struct packed {
      logic                valid;
      logic [PA_W-1:0]     phys;
      logic [STATUS_W-1:0] status;
   } walk_result_type;

endpackage

// File: hw/rtl/ptw_store.sv
// ----------------------------------------------------------------------------
// Page table entry store
// Single-port synchronous memory of 64-bit entry words. The read word is
// registered and holds its value until the next read.
// ----------------------------------------------------------------------------
module ptw_store (
   input  logic                   clock,
   input  ptw_pkg::store_req_type req,
   output logic [ptw_pkg::PTE_W-1:0] rd_data
);
   import ptw_pkg::*;

   logic [PTE_W-1:0] mem [STORE_WORDS];
   logic [PTE_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ptw_walk.sv
// ----------------------------------------------------------------------------
// Walk sequencer
// Accepts one word at a time, writes entries into the store and walks the
// three table levels with one store read per level.
// ----------------------------------------------------------------------------
module ptw_walk (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_func,
   input  logic [ptw_pkg::VA_W-1:0]    req_virt_addr,
   input  logic [ptw_pkg::WIDX_W-1:0]  req_word_index,
   input  logic [ptw_pkg::PTE_W-1:0]   req_word_data,
   input  logic [ptw_pkg::ROOT_W-1:0]  root_page,
   input  logic                        out_free,
   output ptw_pkg::store_req_type      store_req,
   input  logic [ptw_pkg::PTE_W-1:0]   store_rd_data,
   output ptw_pkg::walk_result_type    result
);
   import ptw_pkg::*;

   walk_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_l1_ff, idx_l0_ff;
   logic             accept_walk;

   logic             pte_valid;
   logic             pte_user;
   logic [PN_W-1:0]  pte_pn;
   logic             pte_outside;
   logic [IDX_W-1:0] next_idx;

   // Fields of the entry word that the store returned.
   assign pte_valid   = store_rd_data[PTE_VALID_BIT];
   assign pte_user    = store_rd_data[PTE_USER_BIT];
   assign pte_pn      = store_rd_data[PTE_W-1:10];
   assign pte_outside = pte_pn >= PN_W'(TABLE_PAGES);
   assign next_idx    = (state_ff == WALK_L2) ? idx_l1_ff : idx_l0_ff;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WALK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Lower level indexes are kept for the later reads of the walk.
   always_ff @(posedge clock) begin
      if (accept_walk) begin
         idx_l1_ff <= req_virt_addr[29:21];
         idx_l0_ff <= req_virt_addr[20:12];
      end
   end

   // Next state, store access and result.
   always_comb begin
      state_in          = state_ff;
      req_ready         = 1'b0;
      accept_walk       = 1'b0;
      store_req.wr_en   = 1'b0;
      store_req.rd_en   = 1'b0;
      store_req.addr    = ADDR_W'(req_word_index);
      store_req.wr_data = req_word_data;
      result.valid      = 1'b0;
      result.phys       = '0;
      result.status     = ST_OK;
      case (state_ff)
         WALK_IDLE: begin
            req_ready = out_free;
            if (req_valid && out_free) begin
               if (req_func == FUNC_WRITE) begin
                  // Out of range writes are dropped but still answered.
                  store_req.wr_en = 32'(req_word_index) < STORE_WORDS;
                  result.valid    = 1'b1;
                  result.status   = ST_WRITE;
               end else if (req_virt_addr[VA_W-1:38] != '0) begin
                  result.valid  = 1'b1;
                  result.status = ST_HIGH;
               end else if (32'(root_page) >= TABLE_PAGES) begin
                  result.valid  = 1'b1;
                  result.status = ST_OUTSIDE;
               end else begin
                  accept_walk     = 1'b1;
                  store_req.rd_en = 1'b1;
                  store_req.addr  = {PAGE_W'(root_page), req_virt_addr[38:30]};
                  state_in        = WALK_L2;
               end
            end
         end
         WALK_L2, WALK_L1: begin
            // A terminating entry waits here for the output register.
            if (!pte_valid || pte_outside) begin
               if (out_free) begin
                  result.valid  = 1'b1;
                  result.status = pte_valid ? ST_OUTSIDE : ST_INVALID;
                  state_in      = WALK_IDLE;
               end
            end else begin
               store_req.rd_en = 1'b1;
               store_req.addr  = {pte_pn[PAGE_W-1:0], next_idx};
               state_in        = (state_ff == WALK_L2) ? WALK_L1 : WALK_L0;
            end
         end
         WALK_L0: begin
            if (out_free) begin
               result.valid = 1'b1;
               state_in     = WALK_IDLE;
               if (!pte_valid) begin
                  result.status = ST_INVALID;
               end else if (!pte_user) begin
                  result.status = ST_NOT_USER;
               end else begin
                  result.status = ST_OK;
                  result.phys   = {store_rd_data[PA_W-3:10], 12'b0};
               end
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/sv39_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker core
// Loads page table entries into a local store and translates virtual
// addresses through the three-level table held there.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word: func 0 writes word_data at word_index in the
//   store, func 1 translates virt_addr. Every word gives one rsp_* word with
//   the page-aligned physical address and a status code.
//   csr_* writes root_page, the store page of the level-2 table; write it
//   only while no request is in flight. csr_ready is always high.
// Sequencing:
//   A write or a rejected address is answered in the cycle after it is taken.
//   A full walk makes one store read per table level through the single
//   store port, then answers through the output register. One request
//   is handled at a time, so a new word waits until the walk has finished.
// Reset:
//   Clears the sequencer, the output register and root_page. The store is
//   not cleared; tables must be loaded before they are walked.
// Stall:
//   A result waits in the output register; a new request is taken in the
//   cycle that result leaves, and a walk holds its last level until then.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  logic [ptw_pkg::VA_W-1:0]       req_virt_addr,
   input  logic [ptw_pkg::WIDX_W-1:0]     req_word_index,
   input  logic [ptw_pkg::PTE_W-1:0]      req_word_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ptw_pkg::PA_W-1:0]       rsp_phys_addr,
   output logic [ptw_pkg::STATUS_W-1:0]   rsp_status,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ptw_pkg::ROOT_W-1:0]     csr_root_page
);
   import ptw_pkg::*;

   logic [ROOT_W-1:0]   root_page_ff, root_page_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]     rsp_phys_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                out_free;
   store_req_type       store_req;
   logic [PTE_W-1:0]    store_rd_data;
   walk_result_type     result;

   // Root page register.
   assign csr_ready    = 1'b1;
   assign root_page_in = csr_valid ? csr_root_page : root_page_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_page_ff <= '0;
      end else begin
         root_page_ff <= root_page_in;
      end
   end

   // Output register; free when empty or being taken this cycle.
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = result.valid || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_phys_ff   <= result.phys;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_phys_addr = rsp_phys_ff;
   assign rsp_status    = rsp_status_ff;

   // Walk sequencer.
   ptw_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_virt_addr  (req_virt_addr),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .root_page      (root_page_ff),
      .out_free       (out_free),
      .store_req      (store_req),
      .store_rd_data  (store_rd_data),
      .result         (result)
   );

   // Entry store.
   ptw_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (store_rd_data)
   );

endmodule

// File: hw/rtl/ptw_checker.sv
// ----------------------------------------------------------------------------
// Walker port checker
// Watches the top level ports and flags results that break the block's
// ordering and status rules.
// ----------------------------------------------------------------------------
module ptw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_func,
   input logic [ptw_pkg::VA_W-1:0]       req_virt_addr,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ptw_pkg::PA_W-1:0]       rsp_phys_addr,
   input logic [ptw_pkg::STATUS_W-1:0]   rsp_status
);
   import ptw_pkg::*;

   // A stalled result word stays presented.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("result word dropped or changed while stalled");

   // A write word is answered in the next cycle with the write status.
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_WRITE
      |=> rsp_valid && rsp_status == ST_WRITE && rsp_phys_addr == '0)
      else $error("write word not answered with write status");

   // An address at or above 2^38 is rejected in the next cycle.
   a_high_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func == FUNC_TRANSLATE &&
      req_virt_addr[VA_W-1:38] != '0
      |=> rsp_valid && rsp_status == ST_HIGH)
      else $error("high address not rejected");

   // Only a successful walk carries a physical address.
   a_phys_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_phys_addr == '0)
      else $error("physical address set on a failed result");

endmodule

bind sv39_page_table_walker_core ptw_checker u_ptw_checker (.*);

// File: sim/tb_sv39_page_table_walker_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sv39 page table walker core testbench
// Loads table entries and walks virtual addresses through them. A shadow copy
// of the store and of root_page predicts every response word, and a monitor
// compares each response with the oldest prediction. A walk is only issued
// once every entry it will read has been loaded, so no unwritten store word
// is ever read. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_sv39_page_table_walker_core;
   import ptw_pkg::*;

   // One predicted response word.
   typedef struct {
      logic [PA_W-1:0]     phys;
      logic [STATUS_W-1:0] status;
   } walk_reply_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_func;
   logic [VA_W-1:0]     req_virt_addr;
   logic [WIDX_W-1:0]   req_word_index;
   logic [PTE_W-1:0]    req_word_data;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [PA_W-1:0]     rsp_phys_addr;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_valid;
   logic                csr_ready;
   logic [ROOT_W-1:0]   csr_root_page;

   // Shadow of the store and of root_page, updated as words are taken.
   logic [PTE_W-1:0]    pte_shadow [STORE_WORDS];
   bit                  pte_loaded [STORE_WORDS];
   logic [ROOT_W-1:0]   root_sel;
   walk_reply_type      replies_due [$];
   walk_reply_type      reply_head;
   logic [VA_W-1:0]     recent_va [$];

   int                  errors;
   int                  words_sent;
   int                  loads_sent;
   int                  root_writes;
   int                  status_seen [8];
   int                  gap_pct;
   int                  stall_pct;
   bit                  quiet;

   sv39_page_table_walker_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_virt_addr  (req_virt_addr),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_phys_addr  (rsp_phys_addr),
      .rsp_status     (rsp_status),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_root_page  (csr_root_page)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Walks va through the shadow tables. Returns -1 when the walk completes,
   // or the index of the first unloaded word it would read, with its level.
   function automatic int walk_table(input logic [VA_W-1:0] va,
                                     output logic [PA_W-1:0] pa,
                                     output logic [STATUS_W-1:0] st,
                                     output int miss_level);
      int                page;
      int                lvl;
      int                word;
      logic [PTE_W-1:0]  ent;
      logic [PN_W-1:0]   pn;
      logic [PN_W+11:0]  wide;
      pa = '0;
      st = ST_OK;
      miss_level = 0;
      page = int'(root_sel);
      if (va >= (64'd1 << 38)) begin
         st = ST_HIGH;
         return -1;
      end
      if (page >= TABLE_PAGES) begin
         st = ST_OUTSIDE;
         return -1;
      end
      for (lvl = 2; lvl >= 0; lvl--) begin
         word = page * ENTRIES_PER_PAGE + int'((va >> (12 + 9 * lvl)) & 64'h1FF);
         if (!pte_loaded[word]) begin
            miss_level = lvl;
            return word;
         end
         ent = pte_shadow[word];
         if (!ent[PTE_VALID_BIT]) begin
            st = ST_INVALID;
            return -1;
         end
         pn = ent[PTE_W-1:10];
         if (lvl > 0) begin
            if (pn >= TABLE_PAGES) begin
               st = ST_OUTSIDE;
               return -1;
            end
            page = int'(pn);
         end else if (!ent[PTE_USER_BIT]) begin
            st = ST_NOT_USER;
            return -1;
         end else begin
            wide = {pn, 12'h000};
            pa = wide[PA_W-1:0];
         end
      end
      return -1;
   endfunction

   // Random entry for a given level. Pointers mostly land on a few low pages
   // so that tables get shared between walks.
   function automatic logic [PTE_W-1:0] make_entry(input int lvl);
      logic [PTE_W-1:0] e;
      logic [5:0]       pg;
      int               r;
      e = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 8) begin
         e[PTE_VALID_BIT] = 1'b0;
      end else if (lvl > 0) begin
         e[PTE_VALID_BIT] = 1'b1;
         if (r < 18) begin
            // Page number beyond the store.
            e[10 + $urandom_range(6, 53)] = 1'b1;
         end else begin
            pg = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 7));
            e[PTE_W-1:10] = PN_W'(pg);
         end
      end else begin
         e[PTE_VALID_BIT] = 1'b1;
         e[PTE_USER_BIT]  = (r >= 18);
      end
      return e;
   endfunction

   // Random virtual address: some above the limit, many near earlier ones.
   function automatic logic [VA_W-1:0] pick_va();
      logic [VA_W-1:0] v;
      int              r;
      r = $urandom_range(0, 99);
      v = {$urandom, $urandom};
      if (r < 8) begin
         v[$urandom_range(38, 63)] = 1'b1;
      end else if (r < 55 && recent_va.size() != 0) begin
         v[11:0] = 12'($urandom);
         if ($urandom_range(0, 1) == 0)
            v[20:12] = recent_va[$urandom_range(0, recent_va.size() - 1)][20:12];
         v[VA_W-1:21] = recent_va[$urandom_range(0, recent_va.size() - 1)][VA_W-1:21];
      end else begin
         v[VA_W-1:38] = '0;
      end
      if (v < (64'd1 << 38)) begin
         recent_va.push_back(v);
         if (recent_va.size() > 16)
            void'(recent_va.pop_front());
      end
      return v;
   endfunction

   // Sends one request word and records its predicted response once taken.
   task automatic send_word(input logic func, input logic [VA_W-1:0] va,
                            input logic [WIDX_W-1:0] widx,
                            input logic [PTE_W-1:0] data);
      walk_reply_type rep;
      int             miss;
      int             lvl;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_func       <= func;
      req_virt_addr  <= va;
      req_word_index <= widx;
      req_word_data  <= data;
      req_valid      <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (func == FUNC_WRITE) begin
         pte_shadow[widx] = data;
         pte_loaded[widx] = 1'b1;
         rep.phys   = '0;
         rep.status = ST_WRITE;
         loads_sent++;
      end else begin
         miss = walk_table(va, rep.phys, rep.status, lvl);
      end
      replies_due.push_back(rep);
      words_sent++;
   endtask

   // Loads any entry the walk still lacks, then issues the walk itself.
   task automatic translate_safe(input logic [VA_W-1:0] va);
      logic [PA_W-1:0]     pa;
      logic [STATUS_W-1:0] st;
      int                  miss;
      int                  lvl;
      miss = walk_table(va, pa, st, lvl);
      while (miss >= 0) begin
         send_word(FUNC_WRITE, {$urandom, $urandom}, WIDX_W'(miss), make_entry(lvl));
         miss = walk_table(va, pa, st, lvl);
      end
      send_word(FUNC_TRANSLATE, va, WIDX_W'($urandom), {$urandom, $urandom});
   endtask

   task automatic drain_replies();
      @(negedge clock);
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // root_page changes only with nothing in flight.
   task automatic set_root(input logic [ROOT_W-1:0] value);
      drain_replies();
      @(negedge clock);
      csr_root_page <= value;
      csr_valid     <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      root_sel = value;
      root_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Hand-built tables covering each status and the field extremes.
   task automatic test_directed_walks();
      gap_pct   = 30;
      stall_pct = 30;
      // Full path along the top indexes ending in an all-ones leaf.
      send_word(FUNC_WRITE, '0, 15'd255, 64'h0000_0000_0000_FC01);
      send_word(FUNC_WRITE, '1, 15'd32767, 64'h0000_0000_0000_0401);
      send_word(FUNC_WRITE, '0, 15'd1023, '1);
      translate_safe(64'h0000_003F_FFFF_FFFF);
      // Addresses at and far above the limit.
      translate_safe(64'h0000_0040_0000_0000);
      translate_safe('1);
      // Invalid root entry, then a root entry pointing past the store.
      send_word(FUNC_WRITE, '0, 15'd0, 64'h0);
      translate_safe(64'h0);
      send_word(FUNC_WRITE, '0, 15'd1, 64'h0000_0000_0001_0001);
      translate_safe(64'h4000_0000);
      // Level-1 table at page 2: invalid entry, then a pointer past the store
      // whose permission bits are all set.
      send_word(FUNC_WRITE, '0, 15'd2, 64'h0000_0000_0000_0801);
      send_word(FUNC_WRITE, '0, 15'd1024, 64'h0);
      translate_safe(64'h8000_0000);
      send_word(FUNC_WRITE, '0, 15'd1025, 64'h0000_0000_0001_07FF);
      translate_safe(64'h8020_0000);
      // Non-leaf with permission bits set is still followed to page 3.
      send_word(FUNC_WRITE, '0, 15'd1026, 64'h0000_0000_0000_0C1F);
      send_word(FUNC_WRITE, '0, 15'd1536, 64'h0000_0000_0000_1401);
      translate_safe(64'h8040_0000);
      send_word(FUNC_WRITE, '0, 15'd1537, 64'h0);
      translate_safe(64'h8040_1000);
      send_word(FUNC_WRITE, '0, 15'd1538, 64'h0000_0000_0000_1C11);
      translate_safe(64'h8040_2ABC);
   endtask

   // Highest and lowest root pages.
   task automatic test_root_extremes();
      set_root(6'd63);
      translate_safe(64'h0000_003F_FFFF_FFFF);
      translate_safe(64'h0);
      set_root(6'd0);
      translate_safe(64'h0000_003F_FFFF_FFFF);
   endtask

   // Mostly well-formed walks with table loads filled in on demand, mixed
   // with stray loads anywhere in the store and occasional full drains.
   task automatic test_random_walks(input logic [ROOT_W-1:0] root, input int count,
                                    input int gaps, input int stalls);
      int start;
      int r;
      set_root(root);
      gap_pct   = gaps;
      stall_pct = stalls;
      start = words_sent;
      while (words_sent - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 2)
            drain_replies();
         if (r < 17)
            send_word(FUNC_WRITE, {$urandom, $urandom}, WIDX_W'($urandom),
                      {$urandom, $urandom});
         else
            translate_safe(pick_va());
      end
   endtask

   // Response side: ready drops in random bursts unless the run is quiet.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each response word with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (replies_due.size() == 0) begin
            $error("unexpected response: phys_addr %h status %0d", rsp_phys_addr, rsp_status);
            errors++;
         end else begin
            reply_head = replies_due.pop_front();
            if (rsp_phys_addr !== reply_head.phys) begin
               $error("phys_addr: expected %h, actual %h", reply_head.phys, rsp_phys_addr);
               errors++;
            end
            if (rsp_status !== reply_head.status) begin
               $error("status: expected %0d, actual %0d", reply_head.status, rsp_status);
               errors++;
            end
            status_seen[reply_head.status]++;
         end
      end
   end

   initial begin
      #8_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_WRITE;
      req_virt_addr  = '0;
      req_word_index = '0;
      req_word_data  = '0;
      csr_valid      = 1'b0;
      csr_root_page  = '0;
      root_sel       = '0;
      quiet          = 1'b0;
      gap_pct        = 0;
      stall_pct      = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_walks();
      test_root_extremes();
      test_random_walks(6'd63, 300, 25, 25);
      test_random_walks(6'd0, 300, 0, 0);
      test_random_walks(6'($urandom_range(0, 63)), 300, 15, 40);
      test_random_walks(6'($urandom_range(0, 63)), 300, 40, 10);
      test_random_walks(6'($urandom_range(0, 7)), 300, 20, 20);
      quiet = 1'b1;
      test_random_walks(6'($urandom_range(0, 63)), 300, 0, 0);

      // Let the tail drain and watch for stray responses.
      drain_replies();
      repeat (16) @(posedge clock);

      $display("Sent %0d words: %0d table loads and %0d walks over %0d root settings.",
               words_sent, loads_sent, words_sent - loads_sent, root_writes);
      $display("Walk results: ok %0d, too high %0d, not valid %0d, not user %0d, outside %0d.",
               status_seen[ST_OK], status_seen[ST_HIGH], status_seen[ST_INVALID],
               status_seen[ST_NOT_USER], status_seen[ST_OUTSIDE]);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_store.sv
hw/rtl/ptw_walk.sv
hw/rtl/sv39_page_table_walker_core.sv
hw/rtl/ptw_checker.sv
sim/tb_sv39_page_table_walker_core.sv
